// ===== hdl/binary_to_english_number_words_assert.svh =====
// Assertion macros for the number-to-words reader.
`ifndef BINARY_TO_ENGLISH_NUMBER_WORDS_ASSERT_SVH
`define BINARY_TO_ENGLISH_NUMBER_WORDS_ASSERT_SVH

`ifndef SYNTH
// Concurrent check on an explicit clock and reset.
`define BEW_ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bew assertion failed");
// Concurrent check on the block's own clock and reset.
`define BEW_ASSERT(lbl, prop) \
  `BEW_ASSERT_CLK(lbl, clk_i, !rst_ni, prop)
`else
`define BEW_ASSERT_CLK(lbl, clk, rst, prop)
`define BEW_ASSERT(lbl, prop)
`endif

`endif

// ===== hdl/bew_pkg.sv =====
// Types and constants shared by the number-to-words reader.
`default_nettype none

package bew_pkg;

  localparam int unsigned NUM_W    = 31;
  localparam int unsigned WORD_W   = 5;
  localparam int unsigned NUM_DIGITS = 10;

  // Word codes
  localparam logic [WORD_W-1:0] WORD_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] WORD_TEEN_BASE = 5'd10;
  // Twenty is code 20 for a tens digit of 2
  localparam logic [WORD_W-1:0] WORD_TENS_OFS  = 5'd18;
  localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;
  // Thousand/Million/Billion are 28 + group index 1/2/3
  localparam logic [WORD_W-1:0] WORD_SCALE_OFS = 5'd28;

  // Last shift step of the binary to BCD conversion
  localparam logic [4:0] CONV_LAST = 5'(NUM_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic slot_last;
    logic step_ok;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bew_num_if.sv =====
// Input channel carrying one number per transaction.
`default_nettype none

interface bew_num_if;
  logic                        valid;
  logic                        ready;
  logic [bew_pkg::NUM_W-1:0]   number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

// ===== hdl/bew_word_if.sv =====
// Output channel carrying one word token per transaction.
`default_nettype none

interface bew_word_if;
  logic                        valid;
  logic                        ready;
  logic [bew_pkg::WORD_W-1:0]  word;
  logic                        last;

  modport source (output valid, output word, output last, input ready);
  modport sink   (input valid, input word, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/binary_to_english_number_words.sv =====
// Top level of the number-to-words reader: controller, datapath and checks.
//
//   channel  dir  payload            transaction
//   num_i    in   number[30:0]       one number to read out
//   wrd_o    out  word[4:0], last    one word token, last set on the final one
//
// A number passes, in order, through an accept state, a 31-step bit-serial binary
// to BCD conversion, a walk of 20 token slots (4 groups of 5) and a flush.
// Reset is asynchronous and active low; it leaves the block idle and ready.
// A stalled output holds the token walk; the next number is taken while the
// final token of the previous one still waits in the output register.
`default_nettype none

`include "binary_to_english_number_words_assert.svh"

module binary_to_english_number_words (
  input  logic        clk_i,
  input  logic        rst_ni,
  bew_num_if.sink     num_i,
  bew_word_if.source  wrd_o
);

  bew_pkg::dp_cmd_t cmd;
  bew_pkg::dp_sts_t sts;

  bew_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (num_i.valid),
    .in_ready_o (num_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bew_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .number_i    (num_i.number),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (wrd_o.valid),
    .out_ready_i (wrd_o.ready),
    .out_word_o  (wrd_o.word),
    .out_last_o  (wrd_o.last)
  );

  // A flush that completes leaves the final token in the output register
  `BEW_ASSERT(a_flush_last, (cmd.flush && sts.out_free) |=> (wrd_o.valid && wrd_o.last))
  // No second number is taken the cycle after one is accepted
  `BEW_ASSERT(a_one_in_flight, (num_i.valid && num_i.ready) |=> !num_i.ready)
  // Conversion end hands over to the token walk
  `BEW_ASSERT(a_conv_to_emit, (cmd.shift && sts.conv_done) |=> cmd.step)
  // The last slot hands over to the flush
  `BEW_ASSERT(a_walk_to_flush, (cmd.step && sts.step_ok && sts.slot_last) |=> cmd.flush)

endmodule

`default_nettype wire

// ===== hdl/bew_ctrl.sv =====
// Controller state machine sequencing load, conversion, token walk and flush.
`default_nettype none

module bew_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bew_pkg::dp_sts_t  sts_i,
  output bew_pkg::dp_cmd_t  cmd_o
);

  bew_pkg::state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bew_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bew_pkg::ST_CONV;
        end
      end
      bew_pkg::ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (sts_i.conv_done) begin
          state_d = bew_pkg::ST_EMIT;
        end
      end
      bew_pkg::ST_EMIT: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_ok && sts_i.slot_last) begin
          state_d = bew_pkg::ST_FLUSH;
        end
      end
      bew_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.out_free) begin
          state_d = bew_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bew_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bew_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bew_dp.sv =====
// Datapath: bit-serial BCD conversion, token slot walk, pending and output registers.
`default_nettype none

module bew_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bew_pkg::NUM_W-1:0]    number_i,
  input  bew_pkg::dp_cmd_t             cmd_i,
  output bew_pkg::dp_sts_t             sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bew_pkg::WORD_W-1:0]   out_word_o,
  output logic                         out_last_o
);

  // Token slots within one three-digit group
  typedef enum logic [2:0] {
    SL_HUNDREDS     = 3'd0,
    SL_HUNDRED_WORD = 3'd1,
    SL_TENS         = 3'd2,
    SL_UNITS        = 3'd3,
    SL_SCALE        = 3'd4
  } slot_e;

  logic [bew_pkg::NUM_DIGITS-1:0][3:0] bcd_q, bcd_d, adj;
  logic [bew_pkg::NUM_W-1:0]           bin_q, bin_d;
  logic [4:0]                          cnt_q, cnt_d;
  logic [1:0]                          grp_q, grp_d;
  slot_e                               pos_q, pos_d;
  logic                                pend_valid_q, pend_valid_d;
  logic [bew_pkg::WORD_W-1:0]          pend_word_q, pend_word_d;
  logic                                out_valid_q, out_valid_d;
  logic [bew_pkg::WORD_W-1:0]          out_word_q, out_word_d;
  logic                                out_last_q, out_last_d;

  logic [3:0]                 dig_h, dig_t, dig_u;
  logic                       tok_vld;
  logic [bew_pkg::WORD_W-1:0] tok;
  logic                       out_free, step_ok, advance, push_step, push_flush;

  // Double-dabble adjust: add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < bew_pkg::NUM_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
  end

  // Digits of the current group (group 3 holds the billions digit only)
  always_comb begin
    unique case (grp_q)
      2'd3: begin
        dig_h = 4'd0;     dig_t = 4'd0;     dig_u = bcd_q[9];
      end
      2'd2: begin
        dig_h = bcd_q[8]; dig_t = bcd_q[7]; dig_u = bcd_q[6];
      end
      2'd1: begin
        dig_h = bcd_q[5]; dig_t = bcd_q[4]; dig_u = bcd_q[3];
      end
      2'd0: begin
        dig_h = bcd_q[2]; dig_t = bcd_q[1]; dig_u = bcd_q[0];
      end
    endcase
  end

  // Token produced by the current slot, if any
  always_comb begin
    tok_vld = 1'b0;
    tok     = bew_pkg::WORD_ZERO;
    unique case (pos_q)
      SL_HUNDREDS: begin
        tok_vld = (dig_h != 4'd0);
        tok     = {1'b0, dig_h};
      end
      SL_HUNDRED_WORD: begin
        tok_vld = (dig_h != 4'd0);
        tok     = bew_pkg::WORD_HUNDRED;
      end
      SL_TENS: begin
        if (dig_t == 4'd1) begin
          // ten to nineteen
          tok_vld = 1'b1;
          tok     = bew_pkg::WORD_TEEN_BASE + {1'b0, dig_u};
        end else if (dig_t >= 4'd2) begin
          tok_vld = 1'b1;
          tok     = bew_pkg::WORD_TENS_OFS + {1'b0, dig_t};
        end else begin
          tok_vld = (dig_u != 4'd0);
          tok     = {1'b0, dig_u};
        end
      end
      SL_UNITS: begin
        tok_vld = (dig_t >= 4'd2) && (dig_u != 4'd0);
        tok     = {1'b0, dig_u};
      end
      SL_SCALE: begin
        tok_vld = ((dig_h | dig_t | dig_u) != 4'd0) && (grp_q != 2'd0);
        tok     = bew_pkg::WORD_SCALE_OFS + {3'b000, grp_q};
      end
      default: begin
        tok_vld = 1'b0;
      end
    endcase
  end

  // Handshake bookkeeping
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_ok    = !(tok_vld && pend_valid_q && !out_free);
  assign advance    = cmd_i.step && step_ok;
  assign push_step  = advance && tok_vld && pend_valid_q;
  assign push_flush = cmd_i.flush && out_free;

  assign sts_o.conv_done = (cnt_q == bew_pkg::CONV_LAST);
  assign sts_o.slot_last = (grp_q == 2'd0) && (pos_q == SL_SCALE);
  assign sts_o.step_ok   = step_ok;
  assign sts_o.out_free  = out_free;

  // Conversion and slot walk next values
  always_comb begin
    bcd_d = bcd_q;
    bin_d = bin_q;
    cnt_d = cnt_q;
    grp_d = grp_q;
    pos_d = pos_q;
    if (cmd_i.load) begin
      bcd_d = '0;
      bin_d = number_i;
      cnt_d = 5'd0;
      grp_d = 2'd3;
      pos_d = SL_HUNDREDS;
    end else if (cmd_i.shift) begin
      bcd_d[0] = {adj[0][2:0], bin_q[bew_pkg::NUM_W-1]};
      for (int i = 1; i < bew_pkg::NUM_DIGITS; i++) begin
        bcd_d[i] = {adj[i][2:0], adj[i-1][3]};
      end
      bin_d = {bin_q[bew_pkg::NUM_W-2:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
    end else if (advance) begin
      unique case (pos_q)
        SL_HUNDREDS:     pos_d = SL_HUNDRED_WORD;
        SL_HUNDRED_WORD: pos_d = SL_TENS;
        SL_TENS:         pos_d = SL_UNITS;
        SL_UNITS:        pos_d = SL_SCALE;
        SL_SCALE: begin
          pos_d = SL_HUNDREDS;
          grp_d = grp_q - 2'd1;
        end
        default:         pos_d = SL_HUNDREDS;
      endcase
    end
  end

  // Pending token and output register next values
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_word_d  = pend_word_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      pend_valid_d = 1'b0;
    end else if (advance && tok_vld) begin
      pend_valid_d = 1'b1;
      pend_word_d  = tok;
    end
    if (push_step) begin
      out_valid_d = 1'b1;
      out_word_d  = pend_word_q;
      out_last_d  = 1'b0;
    end else if (push_flush) begin
      // final token; a number with no tokens reads as Zero
      out_valid_d  = 1'b1;
      out_word_d   = pend_valid_q ? pend_word_q : bew_pkg::WORD_ZERO;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= 5'd0;
      grp_q        <= 2'd0;
      pos_q        <= SL_HUNDREDS;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
      grp_q        <= grp_d;
      pos_q        <= pos_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bcd_q       <= bcd_d;
    bin_q       <= bin_d;
    pend_word_q <= pend_word_d;
    out_word_q  <= out_word_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
